// ===== hw/rtl/cbbp_pkg.sv =====
`timescale 1ns / 1ps
package cbbp_pkg;

    localparam int MAX_BLOBS  = 10;
    localparam int MSG_BYTES  = 16;
    localparam int SUM_WORDS  = 5;

    localparam int LEN_W   = $clog2(MSG_BYTES + 1);
    localparam int BIDX_W  = $clog2(MSG_BYTES);
    localparam int WIDX_W  = $clog2(MSG_BYTES / 2);
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 4;
    localparam int K_W     = $clog2(SUM_WORDS);
    localparam int BLOB_DEPTH = 2 * MAX_BLOBS;
    localparam int ADDR_W  = $clog2(BLOB_DEPTH);
    localparam int BLOB_W  = 64;

    localparam logic [7:0] SYNC_LO = 8'h55;
    localparam logic [7:0] SYNC_HI = 8'hAA;

    localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(14);
    localparam logic [LEN_W-1:0] FRAME_LEN = LEN_W'(16);

    // word indices (byte position / 2)
    localparam logic [WIDX_W-1:0] BLOCK_CSUM_WORD = WIDX_W'(1);
    localparam logic [WIDX_W-1:0] FRAME_CSUM_WORD = WIDX_W'(2);
    localparam logic [WIDX_W-1:0] BLOCK_SUM_FIRST = WIDX_W'(2);
    localparam logic [WIDX_W-1:0] FRAME_SUM_FIRST = WIDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_DECIDE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic append;
        logic drop;
        logic clear;
    } t_msg_cmd;

    typedef struct packed {
        logic clear;
        logic add;
    } t_sum_cmd;

    typedef struct packed {
        logic publish;
        logic store;
    } t_store_cmd;

endpackage

// ===== hw/rtl/cbbp_msg.sv =====
`timescale 1ns / 1ps
module cbbp_msg import cbbp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_msg_cmd              i_cmd,
    input  logic [7:0]            i_byte,
    input  logic [WIDX_W-1:0]     i_word_idx,
    input  logic                  i_frame,
    output logic [LEN_W-1:0]      o_len,
    output logic [3:0][7:0]       o_head,
    output logic [15:0]           o_word,
    output logic [BLOB_W-1:0]     o_blob
);

    logic [MSG_BYTES-1:0][7:0] r_bytes;
    logic [LEN_W-1:0]          r_len;
    logic [BIDX_W-1:0]         wr_idx;

    // length guard: a full message restarts at byte zero
    assign wr_idx = (r_len >= LEN_W'(MSG_BYTES)) ? '0 : r_len[BIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.append) begin
            r_len <= LEN_W'(wr_idx) + LEN_W'(1);
        end else if (i_cmd.drop) begin
            r_len <= r_len - LEN_W'(1);
        end else if (i_cmd.clear) begin
            r_len <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_bytes[wr_idx] <= i_byte;
        end else if (i_cmd.drop) begin
            r_bytes <= {r_bytes[MSG_BYTES-1], r_bytes[MSG_BYTES-1:1]};
        end
    end

    assign o_len  = r_len;
    assign o_head = r_bytes[3:0];
    assign o_word = r_bytes[{i_word_idx, 1'b0} +: 2];
    assign o_blob = i_frame ? r_bytes[15:8] : r_bytes[13:6];

endmodule

// ===== hw/rtl/cbbp_sum.sv =====
`timescale 1ns / 1ps
module cbbp_sum import cbbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sum_cmd    i_cmd,
    input  logic [15:0] i_word,
    output logic [15:0] o_acc
);

    logic [15:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.clear) begin
            r_acc <= '0;
        end else if (i_cmd.add) begin
            r_acc <= r_acc + i_word;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/cbbp_store.sv =====
`timescale 1ns / 1ps
module cbbp_store import cbbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_cmd        i_cmd,
    input  logic [BLOB_W-1:0] i_blob,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [BLOB_W-1:0] o_rd_blob,
    output logic [CNT_W-1:0]  o_wr_cnt,
    output logic [CNT_W-1:0]  o_pub_cnt
);

    logic [BLOB_W-1:0]           r_mem [BLOB_DEPTH];
    logic [BLOB_W-1:0]           r_rd_blob;
    logic                        r_ws;
    logic [1:0][CNT_W-1:0]       r_counts;
    logic                        n_ws;
    logic [1:0][CNT_W-1:0]       n_counts;
    logic                        ws_eff;
    logic [CNT_W-1:0]            cnt_eff;
    logic                        wr_ok;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;

    always_comb begin
        ws_eff   = r_ws ^ i_cmd.publish;
        cnt_eff  = i_cmd.publish ? '0 : r_counts[r_ws];
        wr_ok    = i_cmd.store && (cnt_eff < CNT_W'(MAX_BLOBS));
        wr_addr  = (ws_eff ? ADDR_W'(MAX_BLOBS) : '0) + ADDR_W'(cnt_eff);
        rd_addr  = (r_ws ? '0 : ADDR_W'(MAX_BLOBS)) + ADDR_W'(i_rd_idx);
        n_ws     = ws_eff;
        n_counts = r_counts;
        if (i_cmd.publish) begin
            n_counts[ws_eff] = '0;
        end
        if (wr_ok) begin
            n_counts[ws_eff] = cnt_eff + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws     <= 1'b0;
            r_counts <= '0;
        end else begin
            r_ws     <= n_ws;
            r_counts <= n_counts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= i_blob;
        end
        if (i_rd_en) begin
            r_rd_blob <= r_mem[rd_addr];
        end
    end

    assign o_rd_blob = r_rd_blob;
    assign o_wr_cnt  = r_counts[r_ws];
    assign o_pub_cnt = r_counts[~r_ws];

endmodule

// ===== hw/rtl/camera_blob_block_parser.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Beat
// in        i_valid / o_ready     i_mode, i_rx_byte, i_read_index
// out       o_valid / i_ready     o_blob_found, o_pos_x, o_pos_y,
//                                 o_blob_width, o_blob_height, o_published_count
//
// A byte beat passes ST_CHECK, then ST_SUM and ST_DECIDE once a message is
// long enough to check: one 16-bit adder sums the five checksum words, one
// word per cycle. A read beat passes ST_READ and the registered blob memory,
// and a read result sits in the output register until taken; o_ready stays low
// while it waits. Synchronous active-low reset empties the message and
// both frame sides; no clearing pass is needed.
module camera_blob_block_parser import cbbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    input  logic [IDX_W-1:0]  i_read_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_blob_found,
    output logic [15:0]       o_pos_x,
    output logic [15:0]       o_pos_y,
    output logic [15:0]       o_blob_width,
    output logic [15:0]       o_blob_height,
    output logic [CNT_W-1:0]  o_published_count
);

    t_state            r_state, n_state;
    logic [K_W-1:0]    r_k;
    logic              r_frame;
    logic              r_out_valid;
    logic              r_found;
    logic [CNT_W-1:0]  r_cnt;
    logic [BLOB_W-1:0] r_blob;

    t_msg_cmd          msg_cmd;
    t_sum_cmd          sum_cmd;
    t_store_cmd        store_cmd;
    logic [LEN_W-1:0]  msg_len;
    logic [3:0][7:0]   msg_head;
    logic [15:0]       msg_word;
    logic [BLOB_W-1:0] msg_blob;
    logic [WIDX_W-1:0] word_idx;
    logic [15:0]       acc;
    logic [BLOB_W-1:0] rd_blob;
    logic [CNT_W-1:0]  wr_cnt;
    logic [CNT_W-1:0]  pub_cnt;
    logic              accept;
    logic              rd_en;
    logic              found;
    logic              bad_sync;
    logic              is_frame;
    logic              start_sum;
    logic              bad_publish;

    assign o_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign accept  = i_valid && o_ready;
    assign found   = i_read_index < pub_cnt;

    assign bad_sync = (msg_head[0] != SYNC_LO) ||
                      ((msg_len >= LEN_W'(2)) && (msg_head[1] != SYNC_HI));
    assign is_frame = (msg_head[2] == SYNC_LO) && (msg_head[3] == SYNC_HI);
    assign bad_publish = (wr_cnt != '0) && (wr_cnt < CNT_W'(MAX_BLOBS));

    always_comb begin
        n_state   = r_state;
        msg_cmd   = '0;
        sum_cmd   = '0;
        store_cmd = '0;
        rd_en     = 1'b0;
        start_sum = 1'b0;
        word_idx  = (r_frame ? FRAME_SUM_FIRST : BLOCK_SUM_FIRST) + WIDX_W'(r_k);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode) begin
                        rd_en   = found;
                        n_state = ST_READ;
                    end else begin
                        msg_cmd.append = 1'b1;
                        n_state        = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_state = ST_IDLE;
                if (bad_sync) begin
                    msg_cmd.drop      = 1'b1;
                    store_cmd.publish = bad_publish;
                end else if (msg_len >= BLOCK_LEN &&
                             (!is_frame || msg_len >= FRAME_LEN)) begin
                    sum_cmd.clear = 1'b1;
                    start_sum     = 1'b1;
                    n_state       = ST_SUM;
                end
            end
            ST_SUM: begin
                sum_cmd.add = 1'b1;
                if (r_k == K_W'(SUM_WORDS - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                word_idx = r_frame ? FRAME_CSUM_WORD : BLOCK_CSUM_WORD;
                n_state  = ST_IDLE;
                if (acc == msg_word) begin
                    store_cmd.publish = r_frame && (wr_cnt != '0);
                    store_cmd.store   = 1'b1;
                    msg_cmd.clear     = 1'b1;
                end else begin
                    msg_cmd.drop      = 1'b1;
                    store_cmd.publish = bad_publish;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_sum) begin
            r_k     <= '0;
            r_frame <= is_frame;
        end else if (r_state == ST_SUM) begin
            r_k <= r_k + K_W'(1);
        end
        if (accept && i_mode) begin
            r_found <= found;
            r_cnt   <= pub_cnt;
        end
        if (r_state == ST_READ) begin
            r_blob <= r_found ? rd_blob : '0;
        end
    end

    cbbp_msg u_msg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (msg_cmd),
        .i_byte     (i_rx_byte),
        .i_word_idx (word_idx),
        .i_frame    (r_frame),
        .o_len      (msg_len),
        .o_head     (msg_head),
        .o_word     (msg_word),
        .o_blob     (msg_blob)
    );

    cbbp_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sum_cmd),
        .i_word  (msg_word),
        .o_acc   (acc)
    );

    cbbp_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_blob    (msg_blob),
        .i_rd_en   (rd_en),
        .i_rd_idx  (i_read_index),
        .o_rd_blob (rd_blob),
        .o_wr_cnt  (wr_cnt),
        .o_pub_cnt (pub_cnt)
    );

    assign o_valid           = r_out_valid;
    assign o_blob_found      = r_found;
    assign o_pos_x           = r_blob[15:0];
    assign o_pos_y           = r_blob[31:16];
    assign o_blob_width      = r_blob[47:32];
    assign o_blob_height     = r_blob[63:48];
    assign o_published_count = r_cnt;

endmodule
